/* rtl/pirp_pkg.sv */
// Shared constants and tables for the regular polygon point test.
package pirp_pkg;

  localparam int unsigned MIN_SIDES = 3;

  // Configuration register indexes
  typedef enum logic {
    REG_CIRCUMRADIUS = 1'b0,
    REG_SIDE_COUNT   = 1'b1
  } reg_idx_e;

  // Fixed-point constants, unsigned with 30 fraction bits (angles Q3.30, INV_K Q0.30)
  localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;
  localparam longint unsigned HALF_PI_Q30 = TWO_PI_Q30 / 4;
  localparam logic [29:0]     INV_K_Q30   = 30'd652032874;

  // Datapath widths
  localparam int VXW = 36;  // vectoring x/y
  localparam int RXW = 34;  // rotation x/y
  localparam int ZW  = 34;  // angle accumulators

  // Truncated atan(2^-i), unsigned Q0.30
  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
    30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
    30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
    30'd262143,    30'd131071,    30'd65535,     30'd32767,
    30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127,
    30'd63,        30'd31,        30'd15,        30'd7,
    30'd3,         30'd1,         30'd0,         30'd0
  };

endpackage

/* rtl/point_in_regular_polygon.sv */
// Streaming point-in-regular-polygon test, one point per cycle while the receiver keeps up.
//
// Usage: a point arrives on the s_axis channel (point_u in tdata[31:0],
// point_v in tdata[63:32], both signed Q8.24). One transaction on m_axis
// carries the verdict in tdata[0]: 1 when the point is strictly inside the
// regular polygon set by circumradius and side_count; cfg_ready_o is always high.
// Registers are written on the cfg channel (index 0 circumradius, index 1
// side_count) by the user only while idle; the block does not enforce this.
// The pipeline is built from two chains of CORDIC cells, a sector fold of
// clog2(MAX_SIDES) + 1 cells and the multiply stages. It takes one point per
// cycle unless the receiver stalls; rate is set by the single shared advance
// enable of the cell chain.
// Reset clears the valid bits and loads circumradius 1.0 and six sides.
// When the receiver stalls, the whole chain holds and s_axis_tready drops,
// until the waiting result transaction is taken.
module point_in_regular_polygon #(
  parameter int MAX_SIDES     = 64,
  parameter int CORDIC_STAGES = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] point_u, [63:32] point_v
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] inside_res, [7:1] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [30:0] cfg_data_i
);

  localparam int NS  = CORDIC_STAGES;
  localparam int NW  = $clog2(MAX_SIDES + 1);
  localparam int FS  = $clog2(MAX_SIDES);
  localparam int LAT = 6 + FS + 2 * NS;
  localparam int ED  = NS + FS - 1;
  localparam int VXW = pirp_pkg::VXW;
  localparam int RXW = pirp_pkg::RXW;
  localparam int ZW  = pirp_pkg::ZW;
  localparam int PW  = 34 + FS;

  typedef struct packed {
    logic [64:0] r2;
    logic        outside;
    logic [31:0] step;
    logic [30:0] radius;
  } side_a_t;

  typedef struct packed {
    logic        outside;
    logic        inner;
    logic [31:0] rin;
    logic [32:0] rad;
  } side_e_t;

  logic en;
  logic [LAT-1:0] vld_q;

  // stall the whole chain only while a result waits unread
  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // Configuration registers
  logic [30:0] circ_q;
  logic [6:0]  sides_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      circ_q  <= 31'd16777216;
      sides_q <= 7'd6;
    end else if (cfg_valid_i) begin
      case (pirp_pkg::reg_idx_e'(cfg_index_i))
        pirp_pkg::REG_CIRCUMRADIUS: circ_q  <= cfg_data_i;
        pirp_pkg::REG_SIDE_COUNT:   sides_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Sector step table 2pi/n, truncated unsigned Q2.30
  logic [31:0] step_tab [MAX_SIDES+1];

  for (genvar g = 0; g <= MAX_SIDES; g++) begin : g_step
    localparam longint unsigned STEP_V =
      (g < 3) ? 64'd0 : pirp_pkg::TWO_PI_Q30 / g;
    assign step_tab[g] = 32'(STEP_V);
  end

  // Clamp the side count into the table's range
  logic [NW-1:0] n_clamp;

  always_comb begin
    if (int'(sides_q) < int'(pirp_pkg::MIN_SIDES)) begin
      n_clamp = NW'(pirp_pkg::MIN_SIDES);
    end else if (int'(sides_q) > MAX_SIDES) begin
      n_clamp = NW'(MAX_SIDES);
    end else begin
      n_clamp = NW'(sides_q);
    end
  end

  // Stage 1: capture the point with its polygon
  logic signed [31:0] u1_q, v1_q;
  logic [NW-1:0]      n1_q;
  logic [30:0]        r1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      u1_q <= $signed(s_axis_tdata[31:0]);
      v1_q <= $signed(s_axis_tdata[63:32]);
      n1_q <= n_clamp;
      r1_q <= circ_q;
    end
  end

  // Stage 2: squares, table lookup, vectoring pre-rotation
  logic [31:0] au, av;
  logic [63:0] au2_q, av2_q;
  logic [61:0] rout2_q;
  logic [31:0] step2_q;
  logic [30:0] r2r_q;
  logic signed [VXW-1:0] ue, ve;
  logic signed [VXW-1:0] vx [NS+1];
  logic signed [VXW-1:0] vy [NS+1];
  logic signed [ZW-1:0]  vz [NS+1];

  assign au = u1_q[31] ? 32'(-u1_q) : 32'(u1_q);
  assign av = v1_q[31] ? 32'(-v1_q) : 32'(v1_q);
  assign ue = VXW'(u1_q);
  assign ve = VXW'(v1_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      au2_q   <= au * au;
      av2_q   <= av * av;
      rout2_q <= r1_q * r1_q;
      step2_q <= step_tab[n1_q];
      r2r_q   <= r1_q;
      // turn left-half points by a quarter turn first
      if (u1_q < 0) begin
        if (v1_q >= 0) begin
          vx[0] <= ve;
          vy[0] <= -ue;
          vz[0] <= ZW'(pirp_pkg::HALF_PI_Q30);
        end else begin
          vx[0] <= -ve;
          vy[0] <= ue;
          vz[0] <= -ZW'(pirp_pkg::HALF_PI_Q30);
        end
      end else begin
        vx[0] <= ue;
        vy[0] <= ve;
        vz[0] <= '0;
      end
    end
  end

  // Chain A: vectoring for angle and magnitude, rotation for cos(pi/n)
  logic signed [RXW-1:0] hx [NS+1];
  logic signed [RXW-1:0] hy [NS+1];
  logic signed [ZW-1:0]  hz [NS+1];

  assign hx[0] = RXW'(pirp_pkg::INV_K_Q30);
  assign hy[0] = '0;
  assign hz[0] = ZW'({1'b0, step2_q[31:1]});

  for (genvar k = 0; k < NS; k++) begin : g_chain_a
    pirp_cordic_cell #(.XW(VXW), .ZW(ZW), .I(k), .VEC(1'b1)) u_vec (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (vx[k]),
      .y_i   (vy[k]),
      .z_i   (vz[k]),
      .x_o   (vx[k+1]),
      .y_o   (vy[k+1]),
      .z_o   (vz[k+1])
    );
    pirp_cordic_cell #(.XW(RXW), .ZW(ZW), .I(k), .VEC(1'b0)) u_half (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (hx[k]),
      .y_i   (hy[k]),
      .z_i   (hz[k]),
      .x_o   (hx[k+1]),
      .y_o   (hy[k+1]),
      .z_o   (hz[k+1])
    );
  end

  // Radius test data rides alongside chain A
  side_a_t sa_d;
  side_a_t sa_q [NS];

  always_comb begin
    sa_d.r2      = 65'(au2_q) + 65'(av2_q);
    sa_d.outside = sa_d.r2 > 65'(rout2_q);
    sa_d.step    = step2_q;
    sa_d.radius  = r2r_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q[0] <= sa_d;
      for (int k = 1; k < NS; k++) begin
        sa_q[k] <= sa_q[k-1];
      end
    end
  end

  // Stage B: inradius and radius products, shifted sector angle
  side_a_t             sa;
  logic [62:0]         rinr_q, radr_q;
  logic signed [PW-1:0] phi0_q;
  logic [64:0]         r2b_q;
  logic                outb_q;
  logic [31:0]         stepb_q;
  logic [30:0]         halfb_q;

  assign sa = sa_q[NS-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rinr_q  <= sa.radius * hx[NS][31:0];
      radr_q  <= vx[NS][32:0] * pirp_pkg::INV_K_Q30;
      // add at least half a turn of whole steps up front so the fold only
      // ever subtracts
      phi0_q  <= PW'(vz[NS]) + PW'(sa.step[31:1]) + PW'(pirp_pkg::HALF_PI_Q30)
               + (PW'(sa.step) << (FS - 1));
      r2b_q   <= sa.r2;
      outb_q  <= sa.outside;
      stepb_q <= sa.step;
      halfb_q <= sa.step[31:1];
    end
  end

  // Sector fold: floor modulo by the step, one quotient bit per cell
  logic signed [PW-1:0] fphi  [FS+2];
  logic        [31:0]   fstep [FS+2];
  logic        [30:0]   fhalf [FS+2];

  assign fphi[0]  = phi0_q;
  assign fstep[0] = stepb_q;
  assign fhalf[0] = halfb_q;

  for (genvar j = 0; j < FS + 1; j++) begin : g_fold
    pirp_fold_cell #(.PW(PW), .K(FS - j)) u_fold (
      .clk_i  (clk_i),
      .en_i   (en),
      .phi_i  (fphi[j]),
      .step_i (fstep[j]),
      .half_i (fhalf[j]),
      .phi_o  (fphi[j+1]),
      .step_o (fstep[j+1]),
      .half_o (fhalf[j+1])
    );
  end

  // Chain B: cosine of the folded angle
  logic signed [RXW-1:0] cx [NS+1];
  logic signed [RXW-1:0] cy [NS+1];
  logic signed [ZW-1:0]  cz [NS+1];
  logic signed [PW-1:0]  folded;

  assign folded = fphi[FS+1] - PW'(fhalf[FS+1]);
  assign cx[0]  = RXW'(pirp_pkg::INV_K_Q30);
  assign cy[0]  = '0;
  assign cz[0]  = ZW'(folded);

  for (genvar k = 0; k < NS; k++) begin : g_chain_b
    pirp_cordic_cell #(.XW(RXW), .ZW(ZW), .I(k), .VEC(1'b0)) u_rot (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (cx[k]),
      .y_i   (cy[k]),
      .z_i   (cz[k]),
      .x_o   (cx[k+1]),
      .y_o   (cy[k+1]),
      .z_o   (cz[k+1])
    );
  end

  // Stages C, D: inradius, its square, and the incircle test
  logic [31:0] rinc_q, rind_q;
  logic [32:0] radc_q, radd_q;
  logic [64:0] r2c_q, r2d_q;
  logic        outc_q, outd_q;
  logic [63:0] rin2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rinc_q <= rinr_q[61:30];
      radc_q <= radr_q[62:30];
      r2c_q  <= r2b_q;
      outc_q <= outb_q;
      rin2_q <= rinc_q * rinc_q;
      rind_q <= rinc_q;
      radd_q <= radc_q;
      r2d_q  <= r2c_q;
      outd_q <= outc_q;
    end
  end

  // Early verdicts wait for chain B
  side_e_t se_d;
  side_e_t se_q [ED];

  always_comb begin
    se_d.outside = outd_q;
    se_d.inner   = r2d_q < 65'(rin2_q);
    se_d.rin     = rind_q;
    se_d.rad     = radd_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      se_q[0] <= se_d;
      for (int k = 1; k < ED; k++) begin
        se_q[k] <= se_q[k-1];
      end
    end
  end

  // Projection onto the apothem, then the verdict
  side_e_t              se;
  logic signed [67:0]   prod_q;
  logic                 outf_q, innf_q;
  logic [31:0]          rinf_q;
  logic                 res_q;

  assign se = se_q[ED-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= $signed({1'b0, se.rad}) * cx[NS];
      outf_q <= se.outside;
      innf_q <= se.inner;
      rinf_q <= se.rin;
      if (outf_q) begin
        res_q <= 1'b0;
      end else if (innf_q) begin
        res_q <= 1'b1;
      end else begin
        res_q <= $signed(prod_q[67:30]) < $signed({6'b0, rinf_q});
      end
    end
  end

  assign m_axis_tdata = {7'b0, res_q};

endmodule

/* rtl/pirp_cordic_cell.sv */
// One CORDIC micro-rotation cell, vectoring or rotation mode, registered.
module pirp_cordic_cell #(
  parameter int XW  = 34,
  parameter int ZW  = 34,
  parameter int I   = 0,
  parameter bit VEC = 1'b0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);

  localparam logic signed [ZW-1:0] ATAN_I = ZW'(pirp_pkg::ATAN_Q30[I]);

  logic signed [XW-1:0] dx, dy;
  logic                 cw;

  assign dx = y_i >>> I;
  assign dy = x_i >>> I;
  // clockwise step: drive y to zero, or z towards zero from below
  assign cw = VEC ? (y_i > 0) : (z_i < 0);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (cw) begin
        x_o <= x_i + dx;
        y_o <= y_i - dy;
        z_o <= z_i + ATAN_I;
      end else begin
        x_o <= x_i - dx;
        y_o <= y_i + dy;
        z_o <= z_i - ATAN_I;
      end
    end
  end

endmodule

/* rtl/pirp_fold_cell.sv */
// One restoring step of the sector fold: subtract step << K when it fits.
module pirp_fold_cell #(
  parameter int PW = 40,
  parameter int K  = 0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [PW-1:0] phi_i,
  input  logic        [31:0]   step_i,
  input  logic        [30:0]   half_i,
  output logic signed [PW-1:0] phi_o,
  output logic        [31:0]   step_o,
  output logic        [30:0]   half_o
);

  logic signed [PW-1:0] sk;

  assign sk = $signed(PW'(step_i) << K);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      phi_o  <= (phi_i >= sk) ? phi_i - sk : phi_i;
      step_o <= step_i;
      half_o <= half_i;
    end
  end

endmodule

/* rtl/pirp_checker.sv */
// Port-level checks for the polygon test, bound to the top level.
module pirp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready
);

  // hold a result transaction until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // accept input exactly when the output side can advance
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  // reset empties the pipeline and leaves the input open
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid && s_axis_tready)
    else $error("pipeline not empty after reset");

endmodule

bind point_in_regular_polygon pirp_checker u_pirp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
